// File: rtl/lfr_pkg.sv
// Package of the LED fade ramp engine: widths, register codes, reset values,
// and the types shared between the configuration block, the state memory and the step logic.
// Depends on nothing.
`default_nettype none

package lfr_pkg;

  // Channel count and storage geometry.
  localparam int CHANNELS = 4;
  localparam int CHAN_W   = 2;
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths.
  localparam int DUTY_W     = 14;
  localparam int COUNT_W    = 11;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Reset values of the per-channel state.
  localparam logic [DUTY_W-1:0]  DUTY_RESET  = 14'd8000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd0;

  // Reset values of the configuration registers.
  localparam logic [DUTY_W-1:0]  DUTY_MAX_RESET    = 14'd8000;
  localparam logic [DUTY_W-1:0]  HIGH_BAND_RESET   = 14'd6500;
  localparam logic [DUTY_W-1:0]  MID_BAND_RESET    = 14'd4000;
  localparam logic [DUTY_W-1:0]  LOW_BAND_RESET    = 14'd10;
  localparam logic [STEP_W-1:0]  STEP_HIGH_RESET   = 8'd2;
  localparam logic [STEP_W-1:0]  STEP_MID_RESET    = 8'd5;
  localparam logic [STEP_W-1:0]  STEP_LOW_RESET    = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RESET = 11'd1111;

  // Ramp direction codes.
  localparam logic OP_UP   = 1'b0;
  localparam logic OP_DOWN = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_MAX    = 3'd0,
    REG_HIGH_BAND   = 3'd1,
    REG_MID_BAND    = 3'd2,
    REG_LOW_BAND    = 3'd3,
    REG_STEP_HIGH   = 3'd4,
    REG_STEP_MID    = 3'd5,
    REG_STEP_LOW    = 3'd6,
    REG_COUNT_LIMIT = 3'd7
  } lfr_reg_e;

  // Current register settings.
  typedef struct packed {
    logic [DUTY_W-1:0]  duty_max;
    logic [DUTY_W-1:0]  high_band;
    logic [DUTY_W-1:0]  mid_band;
    logic [DUTY_W-1:0]  low_band;
    logic [STEP_W-1:0]  step_high;
    logic [STEP_W-1:0]  step_mid;
    logic [STEP_W-1:0]  step_low;
    logic [COUNT_W-1:0] count_limit;
  } lfr_cfg_t;

  // One channel's stored state.
  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [COUNT_W-1:0] count;
    logic               down;
  } lfr_entry_t;

  // Write request into the state memory.
  typedef struct packed {
    logic               en;
    logic [CHAN_W-1:0]  chan;
    lfr_entry_t         data;
  } lfr_wr_t;

endpackage : lfr_pkg

`default_nettype wire

// File: rtl/lfr_if.sv
// Channel interfaces of the LED fade ramp engine: tick requests, results and
// configuration writes. Depends on lfr_pkg.
`default_nettype none

interface lfr_in_if;
  import lfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic              op;
  modport source (output valid, output channel, output op, input ready);
  modport sink   (input valid, input channel, input op, output ready);
endinterface : lfr_in_if

interface lfr_out_if;
  import lfr_pkg::*;
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_value;
  logic [COUNT_W-1:0] ramp_count;
  logic               ramp_done;
  modport source (output valid, output duty_value, output ramp_count, output ramp_done,
                  input ready);
  modport sink   (input valid, input duty_value, input ramp_count, input ramp_done,
                  output ready);
endinterface : lfr_out_if

interface lfr_cfg_if;
  import lfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : lfr_cfg_if

`default_nettype wire

// File: rtl/led_fade_ramp_engine.sv
// Top level of the LED fade ramp engine: request pipeline around the state
// memory, step logic and result register. Depends on lfr_pkg, lfr_if and the lfr_* modules.
//
//  Port    | Dir | Carries
//  --------+-----+------------------------------------------------
//  in_i    | in  | tick request: channel, op
//  out_o   | out | result: duty_value, ramp_count, ramp_done
//  cfg_i   | in  | register write: index, data
//
// One request per cycle is accepted unless the result stalls; it goes through the step
// stage register and the result register. The state memory's single read port and
// single write port set that rate; a request for the channel written in the same cycle
// takes the written data forward. Reset is asynchronous; entry valid bits give the reset
// state, no clearing pass. A stalled result holds the pipeline; a new request is still
// taken while the step stage is empty.
`default_nettype none

module led_fade_ramp_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lfr_in_if.sink    in_i,
  lfr_out_if.source out_o,
  lfr_cfg_if.sink   cfg_i
);
  import lfr_pkg::*;

  lfr_cfg_t           cfg;
  logic               s1_valid_q;
  logic [CHAN_W-1:0]  s1_chan_q;
  logic               s1_op_q;
  logic               s1_adv;
  logic               s1_in_range;
  logic               accept;
  lfr_entry_t         cur;
  lfr_entry_t         nxt;
  logic               done;
  lfr_wr_t            wr;
  logic               out_valid_q;
  logic [DUTY_W-1:0]  out_duty_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_done_q;

  lfr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake control of the step stage.
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign accept      = in_i.valid && in_i.ready;
  assign s1_in_range = int'(s1_chan_q) < CHANNELS;

  // Write back the updated channel state.
  always_comb begin
    wr.en   = s1_adv && s1_in_range;
    wr.chan = s1_chan_q;
    wr.data = nxt;
  end

  lfr_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_chan_i (in_i.channel),
    .rd_data_o (cur),
    .wr_i      (wr)
  );

  lfr_step_calc u_calc (
    .op_i   (s1_op_q),
    .cur_i  (cur),
    .cfg_i  (cfg),
    .nxt_o  (nxt),
    .done_o (done)
  );

  // Step stage request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_chan_q <= in_i.channel;
      s1_op_q   <= in_i.op;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_duty_q  <= s1_in_range ? nxt.duty  : '0;
      out_count_q <= s1_in_range ? nxt.count : '0;
      out_done_q  <= s1_in_range && done;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.duty_value = out_duty_q;
  assign out_o.ramp_count = out_count_q;
  assign out_o.ramp_done  = out_done_q;

endmodule : led_fade_ramp_engine

`default_nettype wire

// File: rtl/lfr_cfg_regs.sv
// Configuration register file of the LED fade ramp engine.
// Depends on lfr_pkg and lfr_cfg_if.
`default_nettype none

module lfr_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  lfr_cfg_if.sink           cfg,
  output lfr_pkg::lfr_cfg_t cfg_o
);
  import lfr_pkg::*;

  lfr_cfg_t regs_q, regs_d;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Decode the write and mask the data to the register's width.
  always_comb begin
    regs_d = regs_q;
    if (cfg.valid) begin
      unique case (lfr_reg_e'(cfg.index))
        REG_DUTY_MAX:    regs_d.duty_max    = cfg.data[DUTY_W-1:0];
        REG_HIGH_BAND:   regs_d.high_band   = cfg.data[DUTY_W-1:0];
        REG_MID_BAND:    regs_d.mid_band    = cfg.data[DUTY_W-1:0];
        REG_LOW_BAND:    regs_d.low_band    = cfg.data[DUTY_W-1:0];
        REG_STEP_HIGH:   regs_d.step_high   = cfg.data[STEP_W-1:0];
        REG_STEP_MID:    regs_d.step_mid    = cfg.data[STEP_W-1:0];
        REG_STEP_LOW:    regs_d.step_low    = cfg.data[STEP_W-1:0];
        REG_COUNT_LIMIT: regs_d.count_limit = cfg.data[COUNT_W-1:0];
        default:         regs_d = regs_q;
      endcase
    end
  end

  // Register storage with documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.duty_max    <= DUTY_MAX_RESET;
      regs_q.high_band   <= HIGH_BAND_RESET;
      regs_q.mid_band    <= MID_BAND_RESET;
      regs_q.low_band    <= LOW_BAND_RESET;
      regs_q.step_high   <= STEP_HIGH_RESET;
      regs_q.step_mid    <= STEP_MID_RESET;
      regs_q.step_low    <= STEP_LOW_RESET;
      regs_q.count_limit <= COUNT_LIMIT_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule : lfr_cfg_regs

`default_nettype wire

// File: rtl/lfr_state_mem.sv
// Per-channel state memory of the LED fade ramp engine: one synchronous read
// port, one write port, write-to-read forwarding and per-entry valid bits. Depends on lfr_pkg.
`default_nettype none

module lfr_state_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [lfr_pkg::CHAN_W-1:0] rd_chan_i,
  output lfr_pkg::lfr_entry_t             rd_data_o,
  input  wire lfr_pkg::lfr_wr_t           wr_i
);
  import lfr_pkg::*;

  lfr_entry_t            mem [CHANNELS];
  logic [CHANNELS-1:0]   written_q;
  lfr_entry_t            rd_data_q;
  logic                  rd_hit_q;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  fwd;
  lfr_entry_t            reset_entry;

  assign rd_addr = ADDR_W'(rd_chan_i);
  assign wr_addr = ADDR_W'(wr_i.chan);
  // A write landing on the entry read in the same cycle is passed straight through.
  assign fwd     = wr_i.en && (wr_i.chan == rd_chan_i);

  // Memory array write.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.data;
    end
  end

  // Registered read with forwarding.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= fwd ? wr_i.data : mem[rd_addr];
    end
  end

  // Valid bits: an entry never written reads as the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= fwd || written_q[rd_addr];
      end
    end
  end

  always_comb begin
    reset_entry.duty  = DUTY_RESET;
    reset_entry.count = COUNT_RESET;
    reset_entry.down  = 1'b0;
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : reset_entry;

endmodule : lfr_state_mem

`default_nettype wire

// File: rtl/lfr_step_calc.sv
// Ramp step logic of the LED fade ramp engine: computes a channel's next
// duty, count, down and done flags from its state. Depends on lfr_pkg.
`default_nettype none

module lfr_step_calc (
  input  wire logic                op_i,
  input  wire lfr_pkg::lfr_entry_t cur_i,
  input  wire lfr_pkg::lfr_cfg_t   cfg_i,
  output lfr_pkg::lfr_entry_t      nxt_o,
  output logic                     done_o
);
  import lfr_pkg::*;

  logic [DUTY_W-1:0]  reload;
  logic [DUTY_W-1:0]  base;
  logic [DUTY_W-1:0]  step;
  logic [DUTY_W-1:0]  stepped;
  logic               in_band;
  logic [COUNT_W-1:0] count_inc;

  // Duty at the start of a down ramp: count times 8, clamped.
  always_comb begin
    reload = {cur_i.count, 3'b000};
    if (reload >= cfg_i.duty_max) begin
      reload = cfg_i.duty_max;
    end
    base = cur_i.down ? cur_i.duty : reload;
  end

  // Band selection for the decrement.
  always_comb begin
    in_band = 1'b1;
    priority if (base >= cfg_i.high_band) begin
      step = DUTY_W'(cfg_i.step_high);
    end else if (base >= cfg_i.mid_band) begin
      step = DUTY_W'(cfg_i.step_mid);
    end else if (base >= cfg_i.low_band) begin
      step = DUTY_W'(cfg_i.step_low);
    end else if (base != '0) begin
      step = DUTY_W'(1);
    end else begin
      step    = '0;
      in_band = 1'b0;
    end
    stepped = (base >= step) ? (base - step) : '0;
  end

  assign count_inc = cur_i.count + COUNT_W'(1);

  // Next state by direction.
  always_comb begin
    nxt_o  = cur_i;
    done_o = 1'b0;
    if (op_i == OP_DOWN) begin
      if (in_band) begin
        nxt_o.duty  = stepped;
        nxt_o.count = stepped[DUTY_W-1:3];
        nxt_o.down  = 1'b1;
      end else begin
        nxt_o.duty  = '0;
        nxt_o.count = '0;
        nxt_o.down  = 1'b0;
        done_o      = 1'b1;
      end
    end else begin
      nxt_o.down = 1'b0;
      if (cur_i.count < cfg_i.count_limit) begin
        nxt_o.count = count_inc;
        nxt_o.duty  = {count_inc, 3'b000};
      end else begin
        done_o = 1'b1;
      end
    end
  end

endmodule : lfr_step_calc

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for led_fade_ramp_engine: random and directed ramp ticks
// against a per-channel fade predictor, under several register settings.
// Depends on lfr_pkg, the lfr_* channel interfaces and the engine RTL.

module tb;
  import lfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STALL_CYCLES   = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              op;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [COUNT_W-1:0] count;
    logic               done;
  } fade_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Locally held drive values; they are known from time zero.
  logic                  tick_valid = 1'b0;
  logic [CHAN_W-1:0]     tick_ch    = '0;
  logic                  tick_op    = OP_UP;
  logic                  res_ready  = 1'b0;
  logic                  reg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  reg_index  = '0;
  logic [CFG_DATA_W-1:0] reg_data   = '0;
  logic                  recv_hold  = 1'b0;
  logic                  stall_arm  = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int idle_cycles   = 0;

  tick_t        tick_queue[$];
  fade_result_t fade_expect[$];

  // Predictor copy of the registers and of the per-channel state.
  lfr_cfg_t           reg_mirror;
  logic [DUTY_W-1:0]  duty_lvl[CHANNELS];
  logic [COUNT_W-1:0] fade_cnt[CHANNELS];
  logic               down_flag[CHANNELS];

  lfr_in_if  tick_if();
  lfr_out_if res_if();
  lfr_cfg_if reg_if();

  assign tick_if.valid   = tick_valid;
  assign tick_if.channel = tick_ch;
  assign tick_if.op      = tick_op;
  assign res_if.ready    = res_ready;
  assign reg_if.valid    = reg_valid;
  assign reg_if.index    = reg_index;
  assign reg_if.data     = reg_data;

  led_fade_ramp_engine DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (res_if),
    .cfg_i  (reg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Moves one channel one tick up or down and returns what the engine reports.
  function automatic fade_result_t advance_channel(logic [CHAN_W-1:0] ch, logic op);
    logic [DUTY_W-1:0]  duty;
    logic [COUNT_W-1:0] cnt;
    logic [STEP_W-1:0]  dec;
    logic               in_band;
    fade_result_t       res;
    duty     = duty_lvl[ch];
    cnt      = fade_cnt[ch];
    res.done = 1'b0;
    if (op == OP_DOWN) begin
      // The first down tick after an up ramp reloads the duty from the count.
      if (!down_flag[ch]) begin
        down_flag[ch] = 1'b1;
        duty = DUTY_W'({3'b000, cnt} << 3);
        if (duty >= reg_mirror.duty_max) duty = reg_mirror.duty_max;
      end
      in_band = 1'b1;
      dec     = '0;
      if (duty >= reg_mirror.high_band) dec = reg_mirror.step_high;
      else if (duty >= reg_mirror.mid_band) dec = reg_mirror.step_mid;
      else if (duty >= reg_mirror.low_band) dec = reg_mirror.step_low;
      else if (duty != '0) dec = 8'd1;
      else in_band = 1'b0;
      if (in_band) begin
        duty = (duty >= DUTY_W'(dec)) ? duty - DUTY_W'(dec) : '0;
        cnt  = COUNT_W'(duty >> 3);
      end else begin
        // Duty reached zero: the channel is cleared and the ramp ends.
        duty          = '0;
        cnt           = '0;
        down_flag[ch] = 1'b0;
        res.done      = 1'b1;
      end
    end else begin
      down_flag[ch] = 1'b0;
      if (cnt < reg_mirror.count_limit) begin
        cnt  = cnt + 1'b1;
        duty = DUTY_W'({3'b000, cnt} << 3);
      end else begin
        res.done = 1'b1;
      end
    end
    duty_lvl[ch] = duty;
    fade_cnt[ch] = cnt;
    res.duty     = duty;
    res.count    = cnt;
    return res;
  endfunction

  // Tick driver: offers queued requests and predicts each accepted one.
  always @(posedge clk_i) begin : drive_ticks
    tick_t nxt;
    logic  fire;
    if (!rst_ni) begin
      tick_valid <= 1'b0;
    end else begin
      fire = tick_valid && tick_if.ready;
      if (fire) fade_expect.push_back(advance_channel(tick_ch, tick_op));
      if (!tick_valid || fire) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tick_queue.pop_front();
          tick_valid <= 1'b1;
          tick_ch    <= nxt.channel;
          tick_op    <= nxt.op;
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : watch_results
    fade_result_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_if.valid && res_ready) begin
        if (fade_expect.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: result duty=%0d count=%0d done=%0d with no request pending",
                     res_if.duty_value, res_if.ramp_count, res_if.ramp_done);
        end else begin
          want = fade_expect.pop_front();
          if (res_if.duty_value !== want.duty || res_if.ramp_count !== want.count ||
              res_if.ramp_done !== want.done) begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS)
              $display("ERROR: expected duty=%0d count=%0d done=%0d, got %0d %0d %0d",
                       want.duty, want.count, want.done,
                       res_if.duty_value, res_if.ramp_count, res_if.ramp_done);
          end
        end
      end
      res_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so the engine fills up and stalls its input.
  initial begin
    wait (stall_arm);
    @(posedge clk_i);
    recv_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  // Watchdog on cycles where no channel moves anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_valid && tick_if.ready) || (res_if.valid && res_ready) ||
          (reg_valid && reg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // One register write request; the mirror follows on acceptance.
  task automatic write_reg(input lfr_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    reg_valid <= 1'b1;
    reg_index <= idx;
    reg_data  <= val;
    do @(posedge clk_i); while (!reg_if.ready);
    case (idx)
      REG_DUTY_MAX:    reg_mirror.duty_max    = val;
      REG_HIGH_BAND:   reg_mirror.high_band   = val;
      REG_MID_BAND:    reg_mirror.mid_band    = val;
      REG_LOW_BAND:    reg_mirror.low_band    = val;
      REG_STEP_HIGH:   reg_mirror.step_high   = val[STEP_W-1:0];
      REG_STEP_MID:    reg_mirror.step_mid    = val[STEP_W-1:0];
      REG_STEP_LOW:    reg_mirror.step_low    = val[STEP_W-1:0];
      REG_COUNT_LIMIT: reg_mirror.count_limit = val[COUNT_W-1:0];
      default: ;
    endcase
    reg_valid <= 1'b0;
  endtask

  task automatic program_all(input logic [CFG_DATA_W-1:0] dmax, hb, mb, lb, sh, sm, sl, lim);
    write_reg(REG_DUTY_MAX, dmax);
    write_reg(REG_HIGH_BAND, hb);
    write_reg(REG_MID_BAND, mb);
    write_reg(REG_LOW_BAND, lb);
    write_reg(REG_STEP_HIGH, sh);
    write_reg(REG_STEP_MID, sm);
    write_reg(REG_STEP_LOW, sl);
    write_reg(REG_COUNT_LIMIT, lim);
  endtask

  task automatic push_tick(input int ch, input logic op);
    tick_t t;
    t.channel = CHAN_W'(ch);
    t.op      = op;
    tick_queue.push_back(t);
  endtask

  // Ramp-shaped traffic: each channel runs up or down for a while, with some noise.
  task automatic queue_ramp_ticks(input int n);
    int   run_left[CHANNELS];
    logic run_dir[CHANNELS];
    int   ch;
    logic op;
    for (int c = 0; c < CHANNELS; c++) begin
      run_left[c] = 0;
      run_dir[c]  = OP_UP;
    end
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(CHANNELS - 1);
      if (run_left[ch] == 0) begin
        run_dir[ch]  = 1'($urandom_range(1));
        run_left[ch] = (run_dir[ch] == OP_DOWN) ? $urandom_range(120, 1) : $urandom_range(70, 1);
      end
      op = run_dir[ch];
      if ($urandom_range(9) == 0) op = 1'($urandom_range(1));
      run_left[ch] = run_left[ch] - 1;
      push_tick(ch, op);
    end
  endtask

  // Lets the sender and the engine run dry before touching the registers.
  task automatic wait_drained();
    while (tick_queue.size() != 0 || tick_valid || fade_expect.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stimulus: directed ticks, then random phases under changing registers.
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] hb, mb, lb;
    reg_mirror = '{duty_max: DUTY_MAX_RESET, high_band: HIGH_BAND_RESET,
                   mid_band: MID_BAND_RESET, low_band: LOW_BAND_RESET,
                   step_high: STEP_HIGH_RESET, step_mid: STEP_MID_RESET,
                   step_low: STEP_LOW_RESET, count_limit: COUNT_LIMIT_RESET};
    for (int c = 0; c < CHANNELS; c++) begin
      duty_lvl[c]  = DUTY_RESET;
      fade_cnt[c]  = COUNT_RESET;
      down_flag[c] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 56;

    // A down tick on a fresh channel reloads zero and ends at once, twice over.
    push_tick(0, OP_DOWN);
    push_tick(0, OP_DOWN);
    // Short up ramp, then down through the low band, the single steps and the end.
    repeat (3) push_tick(1, OP_UP);
    repeat (8) push_tick(1, OP_DOWN);
    // An up tick between down ticks forces a fresh reload.
    push_tick(2, OP_UP);
    push_tick(2, OP_DOWN);
    push_tick(2, OP_UP);
    push_tick(2, OP_DOWN);
    push_tick(3, OP_UP);
    push_tick(3, OP_UP);
    queue_ramp_ticks(180);
    wait_drained();

    // Small ramps: the reload clamp, every band and both ends are reached often.
    program_all(400, 300, 200, 50, 40, 20, 7, 60);
    queue_ramp_ticks(200);
    wait_drained();

    // Every register at its top value.
    program_all(16383, 16383, 16383, 16383, 255, 255, 255, 2047);
    queue_ramp_ticks(200);
    wait_drained();

    // Bottom values: zero bands catch a zero duty, zero steps hold it, zero limit.
    send_idle_pct = 56;
    recv_idle_pct = 34;
    program_all(0, 0, 0, 1, 0, 0, 0, 0);
    queue_ramp_ticks(150);
    wait_drained();
    write_reg(REG_HIGH_BAND, 5000);
    write_reg(REG_MID_BAND, 0);
    write_reg(REG_STEP_MID, 3);
    write_reg(REG_DUTY_MAX, 1000);
    write_reg(REG_COUNT_LIMIT, 90);
    queue_ramp_ticks(100);
    wait_drained();

    // Random ordered bands.
    hb = CFG_DATA_W'($urandom_range(3000));
    mb = CFG_DATA_W'($urandom_range(hb));
    lb = CFG_DATA_W'($urandom_range((mb > 1) ? mb : 1, 1));
    program_all(CFG_DATA_W'($urandom_range(3000)), hb, mb, lb,
                CFG_DATA_W'($urandom_range(16383)), CFG_DATA_W'($urandom_range(16383)),
                CFG_DATA_W'($urandom_range(16383)), CFG_DATA_W'($urandom_range(16383)));
    queue_ramp_ticks(200);
    wait_drained();

    // Fully random values, upper bits beyond the narrow registers included.
    program_all(CFG_DATA_W'($urandom_range(16383)), CFG_DATA_W'($urandom_range(16383)),
                CFG_DATA_W'($urandom_range(16383)), CFG_DATA_W'($urandom_range(16383, 1)),
                CFG_DATA_W'($urandom_range(16383)), CFG_DATA_W'($urandom_range(16383)),
                CFG_DATA_W'($urandom_range(16383)), CFG_DATA_W'($urandom_range(16383)));
    queue_ramp_ticks(150);
    wait_drained();

    // No idling; a long receiver hold while requests keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_all(2000, 1500, 800, 20, 60, 30, 9, 300);
    queue_ramp_ticks(200);
    stall_arm = 1'b1;
    wait_drained();

    // Back to the reset values, written with junk above the narrow fields.
    program_all(8000, 6500, 4000, 10, 14'h3F02, 14'h2305, 14'h1F0A, 14'h3800 | 14'd1111);
    queue_ramp_ticks(200);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && fade_expect.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : tb

// File: filelist.f
rtl/lfr_pkg.sv
rtl/lfr_if.sv
rtl/lfr_cfg_regs.sv
rtl/lfr_state_mem.sv
rtl/lfr_step_calc.sv
rtl/led_fade_ramp_engine.sv
bench/tb.sv
